@@ rtl/core/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants for the quadratic root solver: result case codes, the
// width of a root word and the default coefficient and fraction widths.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int unsigned CoefBitsDef = 16;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned RootBits    = 48;
  localparam int unsigned CaseBits    = 3;

  typedef logic [CaseBits-1:0] case_t;

  localparam case_t CaseTwo    = 3'd0;
  localparam case_t CaseDouble = 3'd1;
  localparam case_t CaseNone   = 3'd2;
  localparam case_t CaseLinear = 3'd3;
  localparam case_t CaseDegen  = 3'd4;

endpackage

@@ rtl/core/qrs_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One step of a digit-by-digit square root: takes two radicand bits, decides
// one root bit and hands remainder, root and side data to the next cell.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
  parameter int unsigned SqBits = 17,
  parameter int unsigned SbBits = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2*SqBits-1:0] rad_i,
  input  logic [SqBits+2:0]   rem_i,
  input  logic [SqBits-1:0]   root_i,
  input  logic [SbBits-1:0]   sb_i,
  output logic                valid_o,
  output logic [2*SqBits-1:0] rad_o,
  output logic [SqBits+2:0]   rem_o,
  output logic [SqBits-1:0]   root_o,
  output logic [SbBits-1:0]   sb_o
);

  logic [SqBits+2:0] rem_sh;
  logic [SqBits+2:0] trial;
  logic              take;

  assign rem_sh = {rem_i[SqBits:0], rad_i[2*SqBits-1 -: 2]};
  assign trial  = {1'b0, root_i, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[2*SqBits-3:0], 2'b00};
      rem_o  <= take ? (rem_sh - trial) : rem_sh;
      root_o <= {root_i[SqBits-2:0], take};
      sb_o   <= sb_i;
    end
  end

endmodule

@@ rtl/core/qrs_div_cell.sv @@
// ----------------------------------------------------------------------------
// qrs_div_cell
// One step of two restoring divisions that share a divisor: each lane shifts
// in one dividend bit and decides one quotient bit.
// ----------------------------------------------------------------------------
module qrs_div_cell #(
  parameter int unsigned NumBits = 50,
  parameter int unsigned DenBits = 17,
  parameter int unsigned SbBits  = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [NumBits-1:0] n1_i,
  input  logic [NumBits-1:0] n2_i,
  input  logic [DenBits-1:0] den_i,
  input  logic [DenBits:0]   r1_i,
  input  logic [DenBits:0]   r2_i,
  input  logic [NumBits-1:0] q1_i,
  input  logic [NumBits-1:0] q2_i,
  input  logic [SbBits-1:0]  sb_i,
  output logic               valid_o,
  output logic [NumBits-1:0] n1_o,
  output logic [NumBits-1:0] n2_o,
  output logic [DenBits-1:0] den_o,
  output logic [DenBits:0]   r1_o,
  output logic [DenBits:0]   r2_o,
  output logic [NumBits-1:0] q1_o,
  output logic [NumBits-1:0] q2_o,
  output logic [SbBits-1:0]  sb_o
);

  logic [DenBits:0] rs1;
  logic [DenBits:0] rs2;
  logic [DenBits:0] dx;
  logic             ge1;
  logic             ge2;

  assign rs1 = {r1_i[DenBits-1:0], n1_i[NumBits-1]};
  assign rs2 = {r2_i[DenBits-1:0], n2_i[NumBits-1]};
  assign dx  = {1'b0, den_i};
  assign ge1 = (rs1 >= dx);
  assign ge2 = (rs2 >= dx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_o  <= {n1_i[NumBits-2:0], 1'b0};
      n2_o  <= {n2_i[NumBits-2:0], 1'b0};
      den_o <= den_i;
      r1_o  <= ge1 ? (rs1 - dx) : rs1;
      r2_o  <= ge2 ? (rs2 - dx) : rs2;
      q1_o  <= {q1_i[NumBits-2:0], ge1};
      q2_o  <= {q2_i[NumBits-2:0], ge2};
      sb_o  <= sb_i;
    end
  end

endmodule

@@ rtl/core/quadratic_root_solver.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c in signed fixed point.
//
// Input words carry coef_a_i, coef_b_i and coef_c_i on a valid/ready channel;
// each result word carries root_case_o, root_first_o and root_second_o on a
// second valid/ready channel. Results leave in the order the words came in.
// The pipeline is a product stage, a discriminant stage, a row of
// COEF_BITS+1 square root cells, a numerator stage, a row of
// COEF_BITS+2+FRAC_BITS divider cells and an output register. One word is
// accepted in every cycle while the pipeline is not held. When the receiver
// stalls with a result waiting, the whole pipeline holds and in_ready_o drops
// until the result is taken. Reset clears all valid flags; no word is in
// flight afterward.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
  parameter int unsigned COEF_BITS = qrs_pkg::CoefBitsDef,
  parameter int unsigned FRAC_BITS = qrs_pkg::FracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COEF_BITS-1:0]         coef_a_i,
  input  logic signed [COEF_BITS-1:0]         coef_b_i,
  input  logic signed [COEF_BITS-1:0]         coef_c_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [qrs_pkg::CaseBits-1:0]        root_case_o,
  output logic signed [qrs_pkg::RootBits-1:0] root_first_o,
  output logic signed [qrs_pkg::RootBits-1:0] root_second_o
);

  import qrs_pkg::*;

  localparam int unsigned C      = COEF_BITS;
  localparam int unsigned DW     = 2 * C + 2;
  localparam int unsigned SQ     = C + 1;
  localparam int unsigned SB1    = CaseBits + 3 * C;
  localparam int unsigned NSW    = C + 3;
  localparam int unsigned DENW   = C + 1;
  localparam int unsigned NW     = C + 2 + FRAC_BITS;
  localparam int unsigned SB2    = CaseBits + 2;
  localparam int unsigned EW     = ((NW > RootBits - 1) ? NW : RootBits - 1) + 1;
  localparam logic [EW-1:0] LimPos = {{(EW - RootBits + 1){1'b0}}, {(RootBits - 1){1'b1}}};
  localparam logic [EW-1:0] LimNeg = LimPos + 1'b1;

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Products.
  logic                  v1_q;
  logic signed [C-1:0]   a1_q, b1_q, c1_q;
  logic signed [2*C-1:0] bb1_q, ac1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q  <= coef_a_i;
      b1_q  <= coef_b_i;
      c1_q  <= coef_c_i;
      bb1_q <= coef_b_i * coef_b_i;
      ac1_q <= coef_a_i * coef_c_i;
    end
  end

  // Discriminant and case.
  logic signed [DW-1:0] disc;
  case_t                case1;

  assign disc = $signed({{2{bb1_q[2*C-1]}}, bb1_q}) - $signed({ac1_q, 2'b00});

  always_comb begin
    if (a1_q == '0) begin
      case1 = (b1_q == '0) ? CaseDegen : CaseLinear;
    end else if (disc == '0) begin
      case1 = CaseDouble;
    end else if (disc[DW-1]) begin
      case1 = CaseNone;
    end else begin
      case1 = CaseTwo;
    end
  end

  logic            v2_q;
  logic [DW-1:0]   rad2_q;
  logic [SB1-1:0]  sb2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad2_q <= (case1 == CaseTwo) ? disc : '0;
      sb2_q  <= {case1, a1_q, b1_q, c1_q};
    end
  end

  // Square root cells.
  logic            sq_v    [SQ+1];
  logic [DW-1:0]   sq_rad  [SQ+1];
  logic [SQ+2:0]   sq_rem  [SQ+1];
  logic [SQ-1:0]   sq_root [SQ+1];
  logic [SB1-1:0]  sq_sb   [SQ+1];

  assign sq_v[0]    = v2_q;
  assign sq_rad[0]  = rad2_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_sb[0]   = sb2_q;

  for (genvar i = 0; i < SQ; i++) begin : g_sq
    qrs_sqrt_cell #(
      .SqBits(SQ),
      .SbBits(SB1)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(sq_v[i]),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .sb_i   (sq_sb[i]),
      .valid_o(sq_v[i+1]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .sb_o   (sq_sb[i+1])
    );
  end

  // Numerators and divisor.
  case_t                case3;
  logic signed [C-1:0]  a3, b3, c3;
  logic signed [NSW-1:0] bx, sx, num1, num2;
  logic signed [DENW:0]  den;
  logic [NSW-2:0]        mag1, mag2;
  logic [DENW-1:0]       magd;

  assign case3 = case_t'(sq_sb[SQ][SB1-1 -: CaseBits]);
  assign a3    = sq_sb[SQ][3*C-1 -: C];
  assign b3    = sq_sb[SQ][2*C-1 -: C];
  assign c3    = sq_sb[SQ][C-1:0];
  assign bx    = NSW'(b3);
  assign sx    = $signed({2'b00, sq_root[SQ]});

  always_comb begin
    if (case3 == CaseLinear) begin
      num1 = -NSW'(c3);
      num2 = '0;
      den  = (DENW + 1)'(b3);
    end else begin
      num1 = sx - bx;
      num2 = -bx - sx;
      den  = $signed({a3[C-1], a3, 1'b0});
    end
  end

  assign mag1 = num1[NSW-1] ? (NSW - 1)'(-num1) : (NSW - 1)'(num1);
  assign mag2 = num2[NSW-1] ? (NSW - 1)'(-num2) : (NSW - 1)'(num2);
  assign magd = den[DENW] ? DENW'(-den) : den[DENW-1:0];

  logic            v4_q;
  logic [NW-1:0]   n1_4_q, n2_4_q;
  logic [DENW-1:0] d4_q;
  logic [SB2-1:0]  sb4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= sq_v[SQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_4_q <= NW'(mag1) << FRAC_BITS;
      n2_4_q <= NW'(mag2) << FRAC_BITS;
      d4_q   <= (magd == '0) ? DENW'(1) : magd;
      sb4_q  <= {case3, num1[NSW-1] ^ den[DENW], num2[NSW-1] ^ den[DENW]};
    end
  end

  // Divider cells.
  logic            dv_v  [NW+1];
  logic [NW-1:0]   dv_n1 [NW+1];
  logic [NW-1:0]   dv_n2 [NW+1];
  logic [DENW-1:0] dv_d  [NW+1];
  logic [DENW:0]   dv_r1 [NW+1];
  logic [DENW:0]   dv_r2 [NW+1];
  logic [NW-1:0]   dv_q1 [NW+1];
  logic [NW-1:0]   dv_q2 [NW+1];
  logic [SB2-1:0]  dv_sb [NW+1];

  assign dv_v[0]  = v4_q;
  assign dv_n1[0] = n1_4_q;
  assign dv_n2[0] = n2_4_q;
  assign dv_d[0]  = d4_q;
  assign dv_r1[0] = '0;
  assign dv_r2[0] = '0;
  assign dv_q1[0] = '0;
  assign dv_q2[0] = '0;
  assign dv_sb[0] = sb4_q;

  for (genvar i = 0; i < NW; i++) begin : g_div
    qrs_div_cell #(
      .NumBits(NW),
      .DenBits(DENW),
      .SbBits (SB2)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(dv_v[i]),
      .n1_i   (dv_n1[i]),
      .n2_i   (dv_n2[i]),
      .den_i  (dv_d[i]),
      .r1_i   (dv_r1[i]),
      .r2_i   (dv_r2[i]),
      .q1_i   (dv_q1[i]),
      .q2_i   (dv_q2[i]),
      .sb_i   (dv_sb[i]),
      .valid_o(dv_v[i+1]),
      .n1_o   (dv_n1[i+1]),
      .n2_o   (dv_n2[i+1]),
      .den_o  (dv_d[i+1]),
      .r1_o   (dv_r1[i+1]),
      .r2_o   (dv_r2[i+1]),
      .q1_o   (dv_q1[i+1]),
      .q2_o   (dv_q2[i+1]),
      .sb_o   (dv_sb[i+1])
    );
  end

  // Saturation, sign and output register.
  function automatic logic [RootBits-1:0] fix_root(input logic [NW-1:0] q, input logic neg);
    logic [EW-1:0] qx;
    logic [EW-1:0] res;
    qx = EW'(q);
    if (neg) begin
      res = (qx > LimNeg) ? LimNeg : qx;
      res = -res;
    end else begin
      res = (qx > LimPos) ? LimPos : qx;
    end
    return res[RootBits-1:0];
  endfunction

  case_t               case5;
  logic [RootBits-1:0] r1_5, r2_5;

  assign case5 = case_t'(dv_sb[NW][SB2-1 -: CaseBits]);

  always_comb begin
    r1_5 = '0;
    r2_5 = '0;
    case (case5)
      CaseTwo: begin
        r1_5 = fix_root(dv_q1[NW], dv_sb[NW][1]);
        r2_5 = fix_root(dv_q2[NW], dv_sb[NW][0]);
      end
      CaseDouble, CaseLinear: begin
        r1_5 = fix_root(dv_q1[NW], dv_sb[NW][1]);
      end
      default: begin
        r1_5 = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= dv_v[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      root_case_o   <= case5;
      root_first_o  <= r1_5;
      root_second_o <= r2_5;
    end
  end

endmodule

@@ bench/qrs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_checker
// Watches both channels of the quadratic root solver. Every accepted
// coefficient word is turned into its expected root word, and every accepted
// result word is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module qrs_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic signed [15:0]                  coef_a_i,
  input  logic signed [15:0]                  coef_b_i,
  input  logic signed [15:0]                  coef_c_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [qrs_pkg::CaseBits-1:0]        root_case_i,
  input  logic signed [qrs_pkg::RootBits-1:0] root_first_i,
  input  logic signed [qrs_pkg::RootBits-1:0] root_second_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  case_seen_o [5]
);
  import qrs_pkg::*;

  typedef struct packed {
    case_t            rcase;
    logic signed [47:0] first;
    logic signed [47:0] second;
  } roots_t;

  roots_t expected_roots[$];

  function automatic logic signed [47:0] fixed_quot(longint num, longint den);
    longint q;
    q = (num * 65536) / den;
    if (q > 64'sd140737488355327) q = 64'sd140737488355327;
    if (q < -64'sd140737488355328) q = -64'sd140737488355328;
    return q[47:0];
  endfunction

  function automatic longint floor_sqrt(longint d);
    longint r;
    longint cand;
    r = 0;
    for (int bit_i = 20; bit_i >= 0; bit_i--) begin
      cand = r | (64'sd1 << bit_i);
      if (cand * cand <= d) r = cand;
    end
    return r;
  endfunction

  function automatic roots_t solve_roots(longint a, longint b, longint c);
    roots_t r;
    longint disc;
    longint s;
    r = '{rcase: CaseNone, first: '0, second: '0};
    if (a == 0) begin
      if (b == 0) begin
        r.rcase = CaseDegen;
      end else begin
        r.rcase = CaseLinear;
        r.first = fixed_quot(-c, b);
      end
    end else begin
      disc = b * b - 4 * a * c;
      if (disc > 0) begin
        s = floor_sqrt(disc);
        r.rcase  = CaseTwo;
        r.first  = fixed_quot(-b + s, 2 * a);
        r.second = fixed_quot(-b - s, 2 * a);
      end else if (disc == 0) begin
        r.rcase = CaseDouble;
        r.first = fixed_quot(-b, 2 * a);
      end
    end
    return r;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    for (int i = 0; i < 5; i++) case_seen_o[i] = 0;
  end

  always @(posedge clk_i) begin
    roots_t e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        expected_roots.push_back(solve_roots(coef_a_i, coef_b_i, coef_c_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_roots.size() == 0) begin
          $error("result word with no expectation waiting");
          fail_count_o++;
        end else begin
          e = expected_roots.pop_front();
          if (root_case_i < 5) case_seen_o[root_case_i]++;
          if (root_case_i !== e.rcase) begin
            $error("root_case expected %0d actual %0d", e.rcase, root_case_i);
            fail_count_o++;
          end
          if (root_first_i !== e.first) begin
            $error("root_first expected %0d actual %0d", e.first, root_first_i);
            fail_count_o++;
          end
          if (root_second_i !== e.second) begin
            $error("root_second expected %0d actual %0d", e.second, root_second_i);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_roots.size();
    end
  end
endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives coefficient words into the quadratic root solver with random gaps
// on both channels and a long receiver hold-off, then reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import qrs_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] coef_a = '0;
  logic signed [15:0] coef_b = '0;
  logic signed [15:0] coef_c = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CaseBits-1:0]        root_case;
  logic signed [RootBits-1:0] root_first;
  logic signed [RootBits-1:0] root_second;
  int                 fail_count;
  int                 pending;
  int                 case_seen [5];
  bit                 hold_off = 1'b0;
  int                 word_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quadratic_root_solver u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .coef_a_i(coef_a), .coef_b_i(coef_b), .coef_c_i(coef_c),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .root_case_o(root_case), .root_first_o(root_first), .root_second_o(root_second)
  );

  qrs_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .coef_a_i(coef_a), .coef_b_i(coef_b), .coef_c_i(coef_c),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .root_case_i(root_case), .root_first_i(root_first), .root_second_i(root_second),
    .fail_count_o(fail_count), .pending_o(pending), .case_seen_o(case_seen)
  );

  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic logic signed [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 16'(int'($urandom_range(0, 8)) - 4);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return 16'(int'($urandom_range(0, 400)) - 200);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_word(logic signed [15:0] a, logic signed [15:0] b,
                           logic signed [15:0] c);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    coef_a   <= a;
    coef_b   <= b;
    coef_c   <= c;
    do @(posedge clk); while (!in_ready);
    word_count++;
  endtask

  always @(posedge clk) begin
    if (hold_off || $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    logic signed [15:0] k;
    logic signed [15:0] r1;
    logic signed [15:0] r2;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_word(16'sh0000, 16'sh0000, 16'sh0000);
    send_word(16'sh0000, 16'sh0000, 16'sh7fff);
    send_word(16'sh0000, 16'sh0003, 16'sh0007);
    send_word(16'sh0000, 16'sh8000, 16'sh7fff);
    send_word(16'sh0000, 16'sh0001, 16'sh8000);
    send_word(16'sh0000, 16'shffff, 16'sh7fff);
    send_word(16'sh0001, 16'shfffe, 16'sh0001);
    send_word(16'sh0004, 16'sh0004, 16'sh0001);
    send_word(16'sh0001, 16'sh0000, 16'sh0001);
    send_word(16'sh0001, 16'sh0000, 16'shffff);
    send_word(16'sh0002, 16'shfffd, 16'shfffb);
    send_word(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_word(16'sh8000, 16'sh8000, 16'sh8000);
    send_word(16'sh8000, 16'sh7fff, 16'sh7fff);
    send_word(16'sh7fff, 16'sh8000, 16'sh8000);
    send_word(16'sh0001, 16'sh8000, 16'sh8000);
    send_word(16'sh8000, 16'sh0000, 16'sh7fff);
    send_word(16'shffff, 16'sh0000, 16'sh0000);
    send_word(16'sh0001, 16'sh7fff, 16'sh0000);
    send_word(16'sh5555, 16'shaaaa, 16'sh5555);
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (80) send_word(pick_coef(), pick_coef(), pick_coef());
    join
    for (int i = 0; i < 900; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          k  = 16'(int'($urandom_range(1, 60)) * ($urandom_range(0, 1) ? 1 : -1));
          r1 = 16'(int'($urandom_range(0, 100)) - 50);
          r2 = $urandom_range(0, 1) ? r1 : 16'(int'($urandom_range(0, 100)) - 50);
          send_word(k, -k * (r1 + r2), k * r1 * r2);
        end
        1: send_word(16'sh0000, pick_coef(), pick_coef());
        default: send_word(pick_coef(), pick_coef(), pick_coef());
      endcase
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d words; cases two/double/none/linear/degenerate: %0d/%0d/%0d/%0d/%0d",
             word_count, case_seen[0], case_seen[1], case_seen[2], case_seen[3],
             case_seen[4]);
    if (fail_count == 0) begin
      $display("quadratic_root_solver test passed");
    end else begin
      $display("quadratic_root_solver test failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("quadratic_root_solver test failed");
    $finish;
  end
endmodule
